>>> src/lspg_pkg.sv
// Shared types, constants and helper functions of the LED strip pattern generator.
`timescale 1ns / 1ps
package lspg_pkg;

    localparam int LED_COUNT = 12;
    localparam int PIX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CHASE_W   = $clog2(LED_COUNT + 1);
    localparam int MASK_N    = (LED_COUNT < 12) ? LED_COUNT : 12;

    localparam logic [15:0] REFRESH_RESET = 16'd100;
    localparam logic [15:0] BLINK_RESET   = 16'd500;
    localparam logic [15:0] FADE_RESET    = 16'd5;
    localparam logic [7:0]  SET_ONE_BLUE  = 8'd100;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET_ONE = 2'd1,
        CMD_SET_TWO = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_STATIC  = 3'd1,
        MODE_CHASE   = 3'd2,
        MODE_BLINK   = 3'd3,
        MODE_BREATHE = 3'd4,
        MODE_RAINBOW = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_REFRESH = 2'd1,
        CFG_BLINK   = 2'd2,
        CFG_FADE    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_ISSUE = 1'b1
    } t_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic accept;
        logic start_frame;
        logic issue;
    } t_ctrl_cmd;

    typedef struct packed {
        logic fire;
        logic s1_ready;
        logic last_issue;
    } t_dp_status;

    typedef logic [7:0] t_base_tab [LED_COUNT];

    // Wheel position of each LED before the scroll offset is added.
    function automatic t_base_tab lspg_base_table();
        t_base_tab tab;
        for (int p = 0; p < LED_COUNT; p++) begin
            tab[p] = 8'(((LED_COUNT - 1 - p) * 256) / LED_COUNT);
        end
        return tab;
    endfunction

    localparam t_base_tab WHEEL_BASE = lspg_base_table();

    // Exact floor(x / 255) for any x up to 255 * 255, the largest product of two 8-bit values.
    function automatic logic [7:0] lspg_div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    function automatic t_rgb lspg_wheel(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] d;
        logic [9:0] t3;
        t_rgb       c;
        w = (pos == 8'd255) ? 8'd0 : pos;
        if (w < 8'd85) begin
            d = w;
        end else if (w < 8'd170) begin
            d = w - 8'd85;
        end else begin
            d = w - 8'd170;
        end
        t3 = 10'(d) * 10'd3;
        if (w < 8'd85) begin
            c.red   = 8'd255 - t3[7:0];
            c.green = t3[7:0];
            c.blue  = 8'd0;
        end else if (w < 8'd170) begin
            c.red   = 8'd0;
            c.green = 8'd255 - t3[7:0];
            c.blue  = t3[7:0];
        end else begin
            c.red   = t3[7:0];
            c.green = 8'd0;
            c.blue  = 8'd255 - t3[7:0];
        end
        return c;
    endfunction

endpackage

>>> src/led_strip_pattern_generator_top.sv
// Top level of the LED strip pattern generator.
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | command in tuser, select and color in tdata
//  m_axis   | out       | one pixel per transaction, tlast on the final pixel
//  cfg      | in        | write of mode and the three period registers
//
// A write command or a tick that does not start a frame is taken while the controller stays idle.
// A tick that starts a frame holds off the next input transaction until the pixel counter,
// which reads one color per cycle while stage one is ready, has issued every pixel.
// The first pixel passes the issue state, the stage one register and the output register.
// Reset is synchronous, active low and restores all but the snapshot and pipeline data.
// A stall on the output holds the pixel pipeline and the pixel counter.
`timescale 1ns / 1ps
module led_strip_pattern_generator_top
    import lspg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // led_select, red_in, green_in, blue_in
    input  logic [1:0]  i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // pixel_index, red_out, green_out, blue_out
    output logic        o_m_axis_tlast
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    lspg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    lspg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (w_cmd),
        .o_status        (w_status)
    );

endmodule

>>> src/lspg_ctrl.sv
// Controller state machine that accepts commands and sequences frame output.
`timescale 1ns / 1ps
module lspg_ctrl
    import lspg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_s_axis_tready   = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.start_frame = 1'b0;
        o_cmd.issue       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready   = 1'b1;
                o_cmd.accept      = i_s_axis_tvalid;
                o_cmd.start_frame = i_s_axis_tvalid && i_status.fire;
                if (o_cmd.start_frame) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = i_status.s1_ready;
                if (i_status.s1_ready && i_status.last_issue) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/lspg_dp.sv
// Datapath with color stores, animation state and the two-stage pixel pipeline.
`timescale 1ns / 1ps
module lspg_dp
    import lspg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [39:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  t_ctrl_cmd   i_cmd,
    output t_dp_status  o_status
);

    // Configuration registers.
    logic [2:0]  r_mode;
    logic [15:0] r_refresh;
    logic [15:0] r_blink;
    logic [15:0] r_fade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_refresh <= REFRESH_RESET;
            r_blink   <= BLINK_RESET;
            r_fade    <= FADE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:    r_mode    <= i_cfg_data[2:0];
                CFG_REFRESH: r_refresh <= i_cfg_data;
                CFG_BLINK:   r_blink   <= i_cfg_data;
                CFG_FADE:    r_fade    <= i_cfg_data;
                default:     r_mode    <= r_mode;
            endcase
        end
    end

    // Input fields.
    logic [11:0] w_sel;
    t_rgb        w_color;
    logic [1:0]  w_cmd;

    assign w_cmd         = i_s_axis_tuser;
    assign w_sel         = i_s_axis_tdata[11:0];
    assign w_color.red   = i_s_axis_tdata[19:12];
    assign w_color.green = i_s_axis_tdata[27:20];
    assign w_color.blue  = i_s_axis_tdata[35:28];

    logic [LED_COUNT-1:0] w_mask;

    for (genvar g = 0; g < LED_COUNT; g++) begin : g_mask
        if (g < MASK_N) begin : g_used
            assign w_mask[g] = w_sel[g];
        end else begin : g_unused
            assign w_mask[g] = 1'b0;
        end
    end

    t_rgb r_set_one [LED_COUNT];
    t_rgb r_set_two [LED_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_set_one[i] <= '{red: 8'd0, green: 8'd0, blue: SET_ONE_BLUE};
                r_set_two[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                if (w_cmd == CMD_SET_ONE && w_mask[i]) begin
                    r_set_one[i] <= w_color;
                end
                if (w_cmd == CMD_SET_TWO && (w_sel == 12'd0 || w_sel == 12'(i + 1))) begin
                    r_set_two[i] <= w_color;
                end
            end
        end
    end

    // Tick handling and frame decision.
    logic [15:0]        r_elapsed;
    logic [CHASE_W-1:0] r_chase;
    logic               r_phase;
    logic               r_down;
    logic [7:0]         r_level;
    logic [8:0]         r_offset;

    logic [15:0] w_elapsed_inc;
    logic [15:0] w_period;
    logic        w_timed;
    logic        w_fire;
    logic [7:0]  w_level_new;
    logic [8:0]  w_offset_new;

    assign w_elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign w_offset_new  = r_offset + 9'd1;

    always_comb begin
        w_period = r_refresh;
        w_timed  = 1'b1;
        case (r_mode)
            MODE_STATIC, MODE_CHASE:    w_period = r_refresh;
            MODE_BLINK:                 w_period = r_blink;
            MODE_BREATHE, MODE_RAINBOW: w_period = r_fade;
            default:                    w_timed  = 1'b0;
        endcase
        w_fire = (w_cmd == CMD_TICK) &&
                 ((r_mode == MODE_OFF) || (w_timed && w_elapsed_inc > w_period));
        if (!r_down) begin
            w_level_new = (r_level == 8'd255) ? r_level : r_level + 8'd1;
        end else begin
            w_level_new = (r_level == 8'd0) ? r_level : r_level - 8'd1;
        end
    end

    // Frame snapshot, taken when a frame starts and read by the pipeline while the frame is issued.
    logic [2:0]         r_f_mode;
    logic [CHASE_W-1:0] r_f_chase;
    logic               r_f_phase;
    logic [7:0]         r_f_level;
    logic [7:0]         r_f_offset;
    logic [PIX_W-1:0]   r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_chase   <= '0;
            r_phase   <= 1'b0;
            r_down    <= 1'b0;
            r_level   <= '0;
            r_offset  <= '0;
        end else if (i_cmd.accept && w_cmd == CMD_TICK) begin
            r_elapsed <= (w_fire && r_mode != MODE_OFF) ? 16'd0 : w_elapsed_inc;
            if (w_fire) begin
                case (r_mode)
                    MODE_CHASE: begin
                        r_chase <= (r_chase == CHASE_W'(LED_COUNT)) ? '0 : r_chase + 1'b1;
                    end
                    MODE_BLINK: begin
                        r_phase <= ~r_phase;
                    end
                    MODE_BREATHE: begin
                        r_level <= w_level_new;
                        if (!r_down && w_level_new == 8'd255) begin
                            r_down <= 1'b1;
                        end else if (r_down && w_level_new == 8'd0) begin
                            r_down <= 1'b0;
                        end
                    end
                    MODE_RAINBOW: begin
                        r_offset <= (w_offset_new > 9'd255) ? 9'd0 : w_offset_new;
                    end
                    default: begin
                        r_phase <= r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_frame) begin
            r_f_mode   <= r_mode;
            r_f_chase  <= r_chase;
            r_f_phase  <= r_phase;
            r_f_level  <= w_level_new;
            r_f_offset <= w_offset_new[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_cmd.start_frame) begin
            r_pix <= '0;
        end else if (i_cmd.issue) begin
            r_pix <= r_pix + 1'b1;
        end
    end

    // Stage one: pick the pixel color and form the breathe products.
    t_rgb               w_one;
    t_rgb               w_two;
    t_rgb               w_raw;
    logic               w_scale;
    logic [CHASE_W-1:0] w_pix_c;

    assign w_one   = r_set_one[r_pix];
    assign w_two   = r_set_two[r_pix];
    assign w_pix_c = CHASE_W'(r_pix);

    always_comb begin
        w_raw   = '0;
        w_scale = 1'b0;
        case (r_f_mode)
            MODE_STATIC:  w_raw = w_one;
            MODE_CHASE:   w_raw = (w_pix_c < r_f_chase) ? w_one : '0;
            MODE_BLINK:   w_raw = r_f_phase ? w_two : w_one;
            MODE_BREATHE: begin
                w_raw   = w_one;
                w_scale = 1'b1;
            end
            MODE_RAINBOW: w_raw = lspg_wheel(WHEEL_BASE[r_pix] + r_f_offset);
            default:      w_raw = '0;
        endcase
    end

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_idx;
    logic             r_s1_last;
    logic             r_s1_scale;
    logic [15:0]      r_s1_r;
    logic [15:0]      r_s1_g;
    logic [15:0]      r_s1_b;
    logic             w_s2_ready;

    assign w_s2_ready = !o_m_axis_tvalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_status.s1_ready) begin
            r_s1_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_idx   <= r_pix;
            r_s1_last  <= o_status.last_issue;
            r_s1_scale <= w_scale;
            if (w_scale) begin
                r_s1_r <= 16'(w_raw.red) * 16'(r_f_level);
                r_s1_g <= 16'(w_raw.green) * 16'(r_f_level);
                r_s1_b <= 16'(w_raw.blue) * 16'(r_f_level);
            end else begin
                r_s1_r <= 16'(w_raw.red);
                r_s1_g <= 16'(w_raw.green);
                r_s1_b <= 16'(w_raw.blue);
            end
        end
    end

    // Stage two: divide the breathe products by 255 and fill the output register.
    logic       r_out_valid;
    logic [3:0] r_out_idx;
    logic       r_out_last;
    t_rgb       r_out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_out_idx  <= 4'(r_s1_idx);
            r_out_last <= r_s1_last;
            if (r_s1_scale) begin
                r_out_rgb.red   <= lspg_div255(r_s1_r);
                r_out_rgb.green <= lspg_div255(r_s1_g);
                r_out_rgb.blue  <= lspg_div255(r_s1_b);
            end else begin
                r_out_rgb.red   <= r_s1_r[7:0];
                r_out_rgb.green <= r_s1_g[7:0];
                r_out_rgb.blue  <= r_s1_b[7:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {4'd0, r_out_rgb.blue, r_out_rgb.green, r_out_rgb.red,
                              r_out_idx};

    assign o_status.fire       = w_fire;
    assign o_status.s1_ready   = !r_s1_valid || w_s2_ready;
    assign o_status.last_issue = (r_pix == PIX_W'(LED_COUNT - 1));

endmodule

>>> src/lspg_checker.sv
// Port-level assertions for the LED strip pattern generator and their bind.
`timescale 1ns / 1ps
module lspg_checker
    import lspg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic [3:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_exp_idx <= o_m_axis_tlast ? 4'd0 : r_exp_idx + 4'd1;
        end
    end

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid right after reset.");

    a_last_on_final_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tlast == (o_m_axis_tdata[3:0] == 4'(LED_COUNT - 1))))
        else $error("tlast does not match the final pixel.");

    a_pixel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[3:0] == r_exp_idx)
        else $error("Pixels out of ascending order.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("Stalled output transaction changed.");

endmodule

bind led_strip_pattern_generator_top lspg_checker u_lspg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
